// ===== sv/cdm_pkg.sv =====
// Shared types, constants and the control program of the curvature drive mixer.
package cdm_pkg;

	localparam int FRAC_BITS_DEF   = 14;
	localparam int SINE_DEPTH_DEF  = 1024;
	localparam longint K_Q30       = 64'sd1096309313;

	localparam int STICK_W         = 16;
	localparam int DRIVE_W         = 20;
	localparam int ACC_W           = 20;
	localparam int DEADBAND_W      = 15;
	localparam int SLEW_W          = 15;
	localparam int GAIN_W          = 12;
	localparam int SENS_W          = 10;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 15;
	localparam int PC_W            = 4;

	localparam logic [DEADBAND_W-1:0] DEADBAND_RST = DEADBAND_W'(1638);
	localparam logic [SLEW_W-1:0]     SLEW_RST     = SLEW_W'(328);
	localparam logic [GAIN_W-1:0]     GAIN_RST     = GAIN_W'(1024);
	localparam logic [SENS_W-1:0]     SENS_RST     = SENS_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEADBAND,
		CFG_SLEW_STEP,
		CFG_INERTIA_GAIN,
		CFG_TURN_SENS
	} cdm_cfg_e_t;

	typedef enum logic [3:0] {
		OP_LOAD,
		OP_DIFF,
		OP_LIMIT,
		OP_LOOK,
		OP_SIGN,
		OP_MUL_POWER,
		OP_ACC,
		OP_SUM,
		OP_MUL_ANG,
		OP_ANG,
		OP_MUL_SENS,
		OP_MIX,
		OP_MUL_SQ,
		OP_SQ_OUT
	} cdm_op_t;

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_WAIT_IN,
		COND_IN_PLACE,
		COND_WAIT_OUT
	} cdm_cond_t;

	typedef struct packed {
		cdm_op_t          op;
		cdm_cond_t        cond;
		logic [PC_W-1:0]  target;
	} cdm_uword_t;

	typedef struct packed {
		cdm_op_t op;
		logic    fire;
		logic    in_wait;
	} cdm_ctrl_t;

	typedef struct packed {
		logic in_place;
		logic out_free;
	} cdm_status_t;

	typedef struct packed {
		logic signed [STICK_W-1:0] throttle;
		logic signed [STICK_W-1:0] turn;
	} cdm_stick_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] left_drive;
		logic signed [DRIVE_W-1:0] right_drive;
	} cdm_drive_t;

	localparam logic [PC_W-1:0] PC_START = PC_W'(0);
	localparam logic [PC_W-1:0] PC_SQUARE = PC_W'(14);

	function automatic cdm_uword_t ucode(input logic [PC_W-1:0] pc);
		cdm_uword_t w;
		w = '{op: OP_LOAD, cond: COND_NEXT, target: PC_START};
		unique case (pc)
			4'd0:  w = '{op: OP_LOAD,      cond: COND_WAIT_IN,  target: PC_START};
			4'd1:  w = '{op: OP_DIFF,      cond: COND_NEXT,     target: PC_START};
			4'd2:  w = '{op: OP_LIMIT,     cond: COND_NEXT,     target: PC_START};
			4'd3:  w = '{op: OP_LOOK,      cond: COND_NEXT,     target: PC_START};
			4'd4:  w = '{op: OP_SIGN,      cond: COND_NEXT,     target: PC_START};
			4'd5:  w = '{op: OP_LOOK,      cond: COND_NEXT,     target: PC_START};
			4'd6:  w = '{op: OP_SIGN,      cond: COND_IN_PLACE, target: PC_SQUARE};
			4'd7:  w = '{op: OP_MUL_POWER, cond: COND_NEXT,     target: PC_START};
			4'd8:  w = '{op: OP_ACC,       cond: COND_NEXT,     target: PC_START};
			4'd9:  w = '{op: OP_SUM,       cond: COND_NEXT,     target: PC_START};
			4'd10: w = '{op: OP_MUL_ANG,   cond: COND_NEXT,     target: PC_START};
			4'd11: w = '{op: OP_ANG,       cond: COND_NEXT,     target: PC_START};
			4'd12: w = '{op: OP_MUL_SENS,  cond: COND_NEXT,     target: PC_START};
			4'd13: w = '{op: OP_MIX,       cond: COND_WAIT_OUT, target: PC_START};
			4'd14: w = '{op: OP_MUL_SQ,    cond: COND_NEXT,     target: PC_START};
			4'd15: w = '{op: OP_SQ_OUT,    cond: COND_WAIT_OUT, target: PC_START};
			default: w = '{op: OP_LOAD,    cond: COND_WAIT_IN,  target: PC_START};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/cdm_stream_if.sv =====
// Valid/ready channel that carries one item of a given payload type.
interface cdm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/cdm_sine_rom.sv =====
// Sine remap ROM, built at elaboration from a fixed-point series, with registered read.
module cdm_sine_rom #(
	parameter int FRAC_BITS        = cdm_pkg::FRAC_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = cdm_pkg::SINE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr,
	output logic [FRAC_BITS:0]                    data
);
	import cdm_pkg::*;

	localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam longint ONE = 64'sd1 <<< FRAC_BITS;

	function automatic longint sin_q30(input longint a);
		longint a2;
		longint term;
		longint sum;
		a2 = (a * a) >>> 30;
		term = a;
		sum = a;
		term = ((term * a2) >>> 30) / 64'sd6;
		sum = sum - term;
		term = ((term * a2) >>> 30) / 64'sd20;
		sum = sum + term;
		term = ((term * a2) >>> 30) / 64'sd42;
		sum = sum - term;
		term = ((term * a2) >>> 30) / 64'sd72;
		sum = sum + term;
		term = ((term * a2) >>> 30) / 64'sd110;
		sum = sum - term;
		term = ((term * a2) >>> 30) / 64'sd156;
		sum = sum + term;
		term = ((term * a2) >>> 30) / 64'sd210;
		sum = sum - term;
		term = ((term * a2) >>> 30) / 64'sd272;
		sum = sum + term;
		return sum;
	endfunction

	localparam longint DEN = sin_q30(K_Q30);

	logic [FRAC_BITS:0] sine_w [SINE_TABLE_DEPTH+1];

	for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_entry
		localparam longint VAL =
			(sin_q30(K_Q30 * longint'(gi) / SINE_TABLE_DEPTH) * ONE + DEN / 2) / DEN;
		assign sine_w[gi] = (FRAC_BITS+1)'(VAL);
	end

	logic [FRAC_BITS:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= sine_w[addr[AW-1:0]];
	end

	assign data = data_q;
endmodule

// ===== sv/cdm_sequencer.sv =====
// Step counter and control program that steers the mixer datapath.
module cdm_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  cdm_pkg::cdm_status_t status,
	output cdm_pkg::cdm_ctrl_t   ctrl
);
	import cdm_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	cdm_uword_t      w;
	logic            fire;
	logic            taken;

	always_comb begin
		w = ucode(pc_q);
		fire = 1'b1;
		taken = 1'b0;
		unique case (w.cond)
			COND_NEXT: begin
				fire = 1'b1;
			end
			COND_WAIT_IN: begin
				fire = in_valid;
			end
			COND_IN_PLACE: begin
				taken = status.in_place;
			end
			COND_WAIT_OUT: begin
				fire = status.out_free;
				taken = 1'b1;
			end
			default: begin
				fire = 1'b1;
			end
		endcase
		if (!fire) begin
			pc_d = pc_q;
		end else if (taken) begin
			pc_d = w.target;
		end else begin
			pc_d = pc_q + PC_W'(1);
		end
		ctrl.op = w.op;
		ctrl.fire = fire;
		ctrl.in_wait = (w.cond == COND_WAIT_IN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_START;
		end else begin
			pc_q <= pc_d;
		end
	end
endmodule

// ===== sv/cdm_datapath.sv =====
// Mixer datapath: configuration, drive state, shared multiplier and output register.
module cdm_datapath #(
	parameter int FRAC_BITS        = cdm_pkg::FRAC_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = cdm_pkg::SINE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cdm_pkg::cdm_ctrl_t                    ctrl,
	input  cdm_pkg::cdm_stick_t                   stick_data,
	input  logic                                  cfg_we,
	input  logic [cdm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cdm_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] rom_addr,
	input  logic [FRAC_BITS:0]                    rom_data,
	output cdm_pkg::cdm_drive_t                   out_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output cdm_pkg::cdm_status_t                  status
);
	import cdm_pkg::*;

	localparam int F    = FRAC_BITS;
	localparam int AW   = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int XW   = (F + 2 > STICK_W) ? F + 2 : STICK_W;
	localparam int SW   = ((F + 2 > ACC_W) ? F + 2 : ACC_W) + 1;
	localparam int AGW  = STICK_W + 1 + SW - F;
	localparam int MAW0 = (AGW > XW) ? AGW : XW;
	localparam int MAW  = (MAW0 > STICK_W + 2) ? MAW0 : STICK_W + 2;
	localparam int MBW0 = (SW > XW + 1) ? SW : XW + 1;
	localparam int MBW  = (MBW0 > GAIN_W + 1) ? MBW0 : GAIN_W + 1;
	localparam int PW   = MAW + MBW;
	localparam int IW   = XW + AW;
	localparam longint ONE = 64'sd1 <<< F;
	localparam longint LIMIT_RAW = 64'sd20 <<< F;
	localparam longint LIMIT = (LIMIT_RAW > 64'sd524287) ? 64'sd524287 : LIMIT_RAW;
	localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
	localparam longint STICK_MAX = (64'sd1 <<< (STICK_W - 1)) - 64'sd1;

	function automatic logic signed [PW-1:0] tz(input logic signed [PW-1:0] v, input int s);
		logic signed [PW-1:0] mag;
		mag = v[PW-1] ? -v : v;
		mag = mag >>> s;
		return v[PW-1] ? -mag : mag;
	endfunction

	function automatic logic signed [PW-1:0] sat(input logic signed [PW-1:0] v,
			input longint lo, input longint hi);
		logic signed [PW-1:0] r;
		if (v < PW'(lo)) begin
			r = PW'(lo);
		end else if (v > PW'(hi)) begin
			r = PW'(hi);
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic [DEADBAND_W-1:0]      deadband_q;
	logic [SLEW_W-1:0]          slew_q;
	logic [GAIN_W-1:0]          gain_q;
	logic [SENS_W-1:0]          sens_q;
	logic signed [STICK_W-1:0]  last_thr_q;
	logic signed [STICK_W-1:0]  last_turn_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       out_valid_q;
	cdm_drive_t                 out_q;

	logic signed [STICK_W-1:0]  thr_q;
	logic signed [STICK_W-1:0]  trn_q;
	logic signed [STICK_W:0]    diff_q;
	logic signed [STICK_W:0]    dturn_q;
	logic                       inpl_q;
	logic signed [STICK_W-1:0]  lin_q;
	logic signed [XW-1:0]       x_q;
	logic                       neg_q;
	logic [STICK_W:0]           alin_q;
	logic signed [SW-1:0]       sum_q;
	logic signed [AGW-1:0]      ang_q;
	logic signed [PW-1:0]       prod_q;

	logic [XW-1:0]              abs_x;
	logic [XW-1:0]              m_clamp;
	logic [IW-1:0]              idx_w;
	logic signed [MAW-1:0]      ma;
	logic signed [MBW-1:0]      mb;
	logic signed [PW-1:0]       prod_w;
	logic [STICK_W:0]           athr;
	logic [STICK_W:0]           atrn;
	logic signed [STICK_W+1:0]  slew_s;
	logic signed [STICK_W+1:0]  dslew_s;
	logic signed [STICK_W+1:0]  lin_cand;
	logic signed [PW-1:0]       lin_sat;
	logic signed [PW-1:0]       acc_sum;
	logic signed [PW-1:0]       acc_wide;
	logic signed [ACC_W-1:0]    acc_decay;
	logic signed [PW-1:0]       ang2;
	logic signed [PW-1:0]       sq;
	cdm_drive_t                 mix_w;
	cdm_drive_t                 sq_w;
	logic                       out_free;
	logic                       out_load;

	always_comb begin
		abs_x = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
		m_clamp = (abs_x > XW'(ONE)) ? XW'(ONE) : abs_x;
		idx_w = (IW'(m_clamp) * IW'(SINE_TABLE_DEPTH)) >> F;
		rom_addr = idx_w[AW-1:0];

		athr = thr_q[STICK_W-1] ? (STICK_W+1)'(-(STICK_W+1)'(thr_q)) : (STICK_W+1)'(thr_q);
		atrn = trn_q[STICK_W-1] ? (STICK_W+1)'(-(STICK_W+1)'(trn_q)) : (STICK_W+1)'(trn_q);

		slew_s = $signed({3'b000, slew_q});
		dslew_s = $signed({2'b00, slew_q, 1'b0});
		if (inpl_q) begin
			lin_cand = '0;
		end else if ((STICK_W+2)'(diff_q) > slew_s) begin
			lin_cand = (STICK_W+2)'(last_thr_q) + slew_s;
		end else if ((STICK_W+2)'(diff_q) < -dslew_s) begin
			lin_cand = (STICK_W+2)'(last_thr_q) - dslew_s;
		end else begin
			lin_cand = (STICK_W+2)'(thr_q);
		end
		lin_sat = sat(PW'(lin_cand), -(STICK_MAX + 64'sd1), STICK_MAX);

		ma = '0;
		mb = '0;
		unique case (ctrl.op)
			OP_MUL_POWER: begin
				ma = MAW'(dturn_q);
				mb = MBW'({1'b0, gain_q});
			end
			OP_MUL_ANG: begin
				ma = MAW'({1'b0, alin_q});
				mb = MBW'(sum_q);
			end
			OP_MUL_SENS: begin
				ma = MAW'(ang_q);
				mb = MBW'({1'b0, sens_q});
			end
			OP_MUL_SQ: begin
				ma = MAW'(x_q);
				mb = MBW'({1'b0, abs_x});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		prod_w = PW'(ma) * PW'(mb);

		acc_sum = sat(PW'(acc_q) + tz(prod_q, 8), -(ACC_MAX + 64'sd1), ACC_MAX);

		acc_wide = PW'(acc_q);
		if (acc_wide > PW'(ONE)) begin
			acc_decay = ACC_W'(acc_wide - PW'(ONE));
		end else if (acc_wide < -PW'(ONE)) begin
			acc_decay = ACC_W'(acc_wide + PW'(ONE));
		end else begin
			acc_decay = '0;
		end

		ang2 = tz(prod_q, 8);
		mix_w.left_drive = DRIVE_W'(sat(PW'(lin_q) + ang2, -LIMIT, LIMIT));
		mix_w.right_drive = DRIVE_W'(sat(PW'(lin_q) - ang2, -LIMIT, LIMIT));

		sq = tz(prod_q, F);
		sq_w.left_drive = DRIVE_W'(sat(sq, -LIMIT, LIMIT));
		sq_w.right_drive = DRIVE_W'(sat(-sq, -LIMIT, LIMIT));

		out_free = !out_valid_q || out_ready;
		out_load = ctrl.fire && ((ctrl.op == OP_MIX) || (ctrl.op == OP_SQ_OUT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RST;
			slew_q <= SLEW_RST;
			gain_q <= GAIN_RST;
			sens_q <= SENS_RST;
			last_thr_q <= '0;
			last_turn_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cdm_cfg_e_t'(cfg_index))
					CFG_DEADBAND:     deadband_q <= cfg_data[DEADBAND_W-1:0];
					CFG_SLEW_STEP:    slew_q <= cfg_data[SLEW_W-1:0];
					CFG_INERTIA_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
					CFG_TURN_SENS:    sens_q <= cfg_data[SENS_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.fire) begin
				unique case (ctrl.op)
					OP_ACC: begin
						acc_q <= ACC_W'(acc_sum);
					end
					OP_MIX: begin
						acc_q <= acc_decay;
						last_turn_q <= trn_q;
						last_thr_q <= lin_q;
					end
					OP_SQ_OUT: begin
						last_turn_q <= trn_q;
						last_thr_q <= lin_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			unique case (ctrl.op)
				OP_LOAD: begin
					thr_q <= stick_data.throttle;
					trn_q <= stick_data.turn;
					x_q <= XW'(stick_data.turn);
				end
				OP_DIFF: begin
					diff_q <= (STICK_W+1)'(thr_q) - (STICK_W+1)'(last_thr_q);
					dturn_q <= (STICK_W+1)'(trn_q) - (STICK_W+1)'(last_turn_q);
					inpl_q <= (athr < (STICK_W+1)'(deadband_q))
						&& (atrn > (STICK_W+1)'(deadband_q));
				end
				OP_LIMIT: begin
					lin_q <= STICK_W'(lin_sat);
				end
				OP_LOOK: begin
					neg_q <= x_q[XW-1];
				end
				OP_SIGN: begin
					x_q <= neg_q ? -XW'({1'b0, rom_data}) : XW'({1'b0, rom_data});
				end
				OP_MUL_POWER, OP_MUL_ANG, OP_MUL_SENS, OP_MUL_SQ: begin
					prod_q <= prod_w;
				end
				OP_ACC: begin
					alin_q <= lin_q[STICK_W-1] ? (STICK_W+1)'(-(STICK_W+1)'(lin_q))
						: (STICK_W+1)'(lin_q);
				end
				OP_SUM: begin
					sum_q <= SW'(x_q) + SW'(acc_q);
				end
				OP_ANG: begin
					ang_q <= AGW'(tz(prod_q, F));
				end
				OP_MIX: begin
					out_q <= mix_w;
				end
				OP_SQ_OUT: begin
					out_q <= sq_w;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_data = out_q;
	assign out_valid = out_valid_q;
	assign status.in_place = inpl_q;
	assign status.out_free = out_free;
endmodule

// ===== sv/curvature_drive_mixer.sv =====
// Curvature drive mixer: sequencer, datapath and sine ROM behind item channels.
// A curvature-mode item walks the steps up to the mix, a turn-in-place item branches to
// the squaring steps after the remap; the result is registered once the output is free.
// The rate is set by the step program walking one shared multiplier and one ROM port.
// A finished result waits in the output register while the next item is worked on.
// arst_n clears the drive state and restores the register defaults; the ROM needs no fill.
module curvature_drive_mixer #(
	parameter int FRAC_BITS        = cdm_pkg::FRAC_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = cdm_pkg::SINE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cdm_stream_if.sink                    stick,
	cdm_stream_if.source                  drive,
	input  logic                          cfg_we,
	input  logic [cdm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cdm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cdm_pkg::*;

	localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

	cdm_ctrl_t          ctrl;
	cdm_status_t        status;
	logic [AW-1:0]      rom_addr;
	logic [FRAC_BITS:0] rom_data;
	cdm_stick_t         stick_data;
	cdm_drive_t         out_data;
	logic               out_valid;

	assign stick_data = stick.data;
	assign stick.ready = ctrl.in_wait;
	assign drive.valid = out_valid;
	assign drive.data = out_data;

	cdm_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stick.valid),
		.status   (status),
		.ctrl     (ctrl)
	);

	cdm_sine_rom #(
		.FRAC_BITS        (FRAC_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	cdm_datapath #(
		.FRAC_BITS        (FRAC_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stick_data (stick_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rom_addr   (rom_addr),
		.rom_data   (rom_data),
		.out_data   (out_data),
		.out_valid  (out_valid),
		.out_ready  (drive.ready),
		.status     (status)
	);
endmodule
